// ----- hdl/sbpq_pkg.sv -----
// ----------------------------------------------------------------------------
// sbpq_pkg: shared types, constants and palette tables
// Source geometry, field widths, register map, request structs and the fixed
// EGA / CGA color tables used by the quantizer cells.
// ----------------------------------------------------------------------------
package sbpq_pkg;

    // Source frame geometry
    localparam int SRC_WIDTH  = 320;
    localparam int SRC_HEIGHT = 200;
    localparam int COL_W      = $clog2(SRC_WIDTH);
    localparam int ROW_W      = $clog2(SRC_HEIGHT);

    // Field widths
    localparam int COORD_W  = 12;
    localparam int SIZE_W   = 7;
    localparam int PIX_W    = 32;
    localparam int RGB_W    = 24;
    localparam int CHAN_W   = 8;
    localparam int DIST_W   = 10;
    localparam int MODE_W   = 2;
    localparam int PROD_W   = COORD_W + SIZE_W;
    localparam int MAX_FILL = 64;

    // Palette sizes; one cell per EGA entry
    localparam int EGA_N      = 16;
    localparam int CGA_N      = 4;
    localparam int CGA_IDX_W  = $clog2(CGA_N);
    localparam int NCELL      = EGA_N;
    localparam int CELL_IDX_W = $clog2(NCELL);

    // Register map (index = paddr[3:2])
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_PALETTE_MODE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SCALE_ENABLE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DEST_WIDTH   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_DEST_HEIGHT  = 2'd3;

    // palette_mode register codes
    localparam logic [MODE_W-1:0] PAL_MODE_OFF = 2'd0;
    localparam logic [MODE_W-1:0] PAL_MODE_EGA = 2'd1;

    // Register reset values
    localparam logic [COORD_W-1:0] DEST_WIDTH_RST  = 12'd320;
    localparam logic [COORD_W-1:0] DEST_HEIGHT_RST = 12'd200;

    // Color handling chosen for one request
    typedef enum logic [1:0] {
        QUANT_RAW = 2'd0,
        QUANT_EGA = 2'd1,
        QUANT_CGA = 2'd2
    } quant_t;

    // One fill request traveling down the cell chain
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SIZE_W-1:0]  size;
        logic [PIX_W-1:0]   pixel;
        logic               frame_end;
        quant_t             quant;
    } fill_req_t;

    // Best palette match found so far
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [RGB_W-1:0]  color;
    } best_t;

    function automatic logic [RGB_W-1:0] ega_color(input logic [CELL_IDX_W-1:0] idx);
        logic [RGB_W-1:0] c;
        case (idx)
            4'd0:    c = 24'h000000;
            4'd1:    c = 24'h0000AA;
            4'd2:    c = 24'h00AA00;
            4'd3:    c = 24'h00AAAA;
            4'd4:    c = 24'hAA0000;
            4'd5:    c = 24'hAA00AA;
            4'd6:    c = 24'hAA5500;
            4'd7:    c = 24'hAAAAAA;
            4'd8:    c = 24'h555555;
            4'd9:    c = 24'h5555FF;
            4'd10:   c = 24'h55FF55;
            4'd11:   c = 24'h55FFFF;
            4'd12:   c = 24'hFF5555;
            4'd13:   c = 24'hFF55FF;
            4'd14:   c = 24'hFFFF55;
            4'd15:   c = 24'hFFFFFF;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

    function automatic logic [RGB_W-1:0] cga_color(input logic [CGA_IDX_W-1:0] idx);
        logic [RGB_W-1:0] c;
        case (idx)
            2'd0:    c = 24'h000000;
            2'd1:    c = 24'h55FFFF;
            2'd2:    c = 24'hFF55FF;
            2'd3:    c = 24'hFFFFFF;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

    function automatic logic [CHAN_W-1:0] abs_diff8(input logic [CHAN_W-1:0] a,
                                                    input logic [CHAN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ----- hdl/sbpq_cell.sv -----
// ----------------------------------------------------------------------------
// sbpq_cell: one palette compare cell
// Holds one request, measures the L1 distance from its pixel to this cell's
// palette entry and keeps the nearer of that entry and the incoming best.
// ----------------------------------------------------------------------------
module sbpq_cell
    import sbpq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CELL_IDX_W-1:0] cell_index,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  fill_req_t             up_req,
    input  best_t                 up_best,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output fill_req_t             dn_req,
    output best_t                 dn_best
);

    logic             valid_reg, valid_next;
    fill_req_t        req_reg;
    best_t            best_reg, best_next;
    logic             entry_en;
    logic [RGB_W-1:0] entry;
    logic [DIST_W-1:0] entry_dist;
    logic             load;

    // Palette entry this cell stands for under the request's palette
    always_comb
    begin
        entry_en = (up_req.quant == QUANT_EGA) ||
                   ((up_req.quant == QUANT_CGA) &&
                    (cell_index < CELL_IDX_W'(CGA_N)));
        entry    = (up_req.quant == QUANT_EGA) ? ega_color(cell_index)
                                               : cga_color(cell_index[CGA_IDX_W-1:0]);
    end

    // L1 distance over the three 8-bit channels
    assign entry_dist = DIST_W'(abs_diff8(up_req.pixel[23:16], entry[23:16]))
                      + DIST_W'(abs_diff8(up_req.pixel[15:8],  entry[15:8]))
                      + DIST_W'(abs_diff8(up_req.pixel[7:0],   entry[7:0]));

    // Strictly nearer wins, so the earlier entry keeps ties
    always_comb
    begin
        if (entry_en && (entry_dist < up_best.distance))
        begin
            best_next.distance = entry_dist;
            best_next.color    = entry;
        end
        else
        begin
            best_next = up_best;
        end
    end

    // Stage handshake: take a request when empty or draining
    assign up_ready   = !valid_reg || dn_ready;
    assign load       = up_valid && up_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg  <= up_req;
            best_reg <= best_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_req   = req_reg;
    assign dn_best  = best_reg;

endmodule

// ----- hdl/scaled_blit_palette_quantizer.sv -----
// ----------------------------------------------------------------------------
// scaled_blit_palette_quantizer: scaled blit fill command generator
// Counts source pixels in raster order, issues one square fill per pixel at
// the integer scale and maps the color to the EGA or CGA palette when enabled and scaling.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Direction
//  --------  ----------------------------------------  ---------
//  source    src_valid, src_ready, src_pixel           in
//  fill      fill_valid, fill_ready, fill_x, fill_y,   out
//            fill_size, fill_color, frame_end
//  config    psel, penable, pwrite, paddr, pwdata,     in/out
//            prdata, pready (APB, always ready)
//
//  One request per clock sustained while fill_ready stays high. An accepted
//  request enters the first cell at the accepting edge, then passes the
//  other fifteen cells and the output register. Each cell stage only waits
//  on its own neighbor, so the chain keeps taking requests while a finished
//  command waits in the output register, until every cell holds one. Reset
//  clears the counters and the valid bits and sets the config reset values.
//
module scaled_blit_palette_quantizer
    import sbpq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // source pixels
    input  logic               src_valid,
    output logic               src_ready,
    input  logic [PIX_W-1:0]   src_pixel,
    // fill commands
    output logic               fill_valid,
    input  logic               fill_ready,
    output logic [COORD_W-1:0] fill_x,
    output logic [COORD_W-1:0] fill_y,
    output logic [SIZE_W-1:0]  fill_size,
    output logic [PIX_W-1:0]   fill_color,
    output logic               frame_end
);

    // Configuration registers
    logic [MODE_W-1:0]    palette_mode_reg;
    logic                 scale_enable_reg;
    logic [COORD_W-1:0]   dest_width_reg;
    logic [COORD_W-1:0]   dest_height_reg;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;

    // Raster position
    logic [COL_W-1:0]   col_count_reg, col_count_next;
    logic [ROW_W-1:0]   row_count_reg, row_count_next;
    logic [COORD_W-1:0] dest_x_acc_reg, dest_x_acc_next;
    logic [COORD_W-1:0] dest_y_acc_reg, dest_y_acc_next;

    logic              scaled;
    logic [SIZE_W-1:0] scale_fit;
    logic [SIZE_W-1:0] scale;
    quant_t            quant;
    logic              row_last;
    logic              frame_last;
    logic              src_accept;

    // Cell chain links
    logic      chain_valid [0:NCELL];
    logic      chain_ready [0:NCELL];
    fill_req_t chain_req   [0:NCELL];
    best_t     chain_best  [0:NCELL];

    // Output register
    logic               fill_valid_reg, fill_valid_next;
    logic [COORD_W-1:0] fill_x_reg;
    logic [COORD_W-1:0] fill_y_reg;
    logic [SIZE_W-1:0]  fill_size_reg;
    logic [PIX_W-1:0]   fill_color_reg;
    logic               frame_end_reg;
    logic               fill_load;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_mode_reg <= PAL_MODE_OFF;
            scale_enable_reg <= 1'b1;
            dest_width_reg   <= DEST_WIDTH_RST;
            dest_height_reg  <= DEST_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_PALETTE_MODE: palette_mode_reg <= pwdata[MODE_W-1:0];
                REG_SCALE_ENABLE: scale_enable_reg <= pwdata[0];
                REG_DEST_WIDTH:   dest_width_reg   <= pwdata[COORD_W-1:0];
                REG_DEST_HEIGHT:  dest_height_reg  <= pwdata[COORD_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PALETTE_MODE: prdata = PDATA_W'(palette_mode_reg);
            REG_SCALE_ENABLE: prdata = PDATA_W'(scale_enable_reg);
            REG_DEST_WIDTH:   prdata = PDATA_W'(dest_width_reg);
            REG_DEST_HEIGHT:  prdata = PDATA_W'(dest_height_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Integer scale: largest k <= MAX_FILL with k*SRC fitting both ways
    // ------------------------------------------------------------------
    always_comb
    begin
        scale_fit = SIZE_W'(1);
        for (int k = 1; k <= MAX_FILL; k++)
        begin
            if ((PROD_W'(dest_width_reg)  >= PROD_W'(k * SRC_WIDTH)) &&
                (PROD_W'(dest_height_reg) >= PROD_W'(k * SRC_HEIGHT)))
            begin
                scale_fit = SIZE_W'(k);
            end
        end
    end

    assign scaled = scale_enable_reg &&
                    ((dest_width_reg  != COORD_W'(SRC_WIDTH)) ||
                     (dest_height_reg != COORD_W'(SRC_HEIGHT)));
    assign scale  = scaled ? scale_fit : SIZE_W'(1);

    // Palette selection; mode three behaves as CGA
    always_comb
    begin
        if (!scaled || (palette_mode_reg == PAL_MODE_OFF))
        begin
            quant = QUANT_RAW;
        end
        else if (palette_mode_reg == PAL_MODE_EGA)
        begin
            quant = QUANT_EGA;
        end
        else
        begin
            quant = QUANT_CGA;
        end
    end

    // ------------------------------------------------------------------
    // Raster counters and destination corner
    // ------------------------------------------------------------------
    assign src_ready  = chain_ready[0];
    assign src_accept = src_valid && src_ready;
    assign row_last   = col_count_reg >= COL_W'(SRC_WIDTH - 1);
    assign frame_last = row_last && (row_count_reg >= ROW_W'(SRC_HEIGHT - 1));

    always_comb
    begin
        col_count_next  = col_count_reg;
        row_count_next  = row_count_reg;
        dest_x_acc_next = dest_x_acc_reg;
        dest_y_acc_next = dest_y_acc_reg;
        if (src_accept)
        begin
            if (row_last)
            begin
                col_count_next  = '0;
                dest_x_acc_next = '0;
                if (frame_last)
                begin
                    row_count_next  = '0;
                    dest_y_acc_next = '0;
                end
                else
                begin
                    row_count_next  = row_count_reg + ROW_W'(1);
                    dest_y_acc_next = dest_y_acc_reg + COORD_W'(scale);
                end
            end
            else
            begin
                col_count_next  = col_count_reg + COL_W'(1);
                dest_x_acc_next = dest_x_acc_reg + COORD_W'(scale);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg  <= '0;
            row_count_reg  <= '0;
            dest_x_acc_reg <= '0;
            dest_y_acc_reg <= '0;
        end
        else
        begin
            col_count_reg  <= col_count_next;
            row_count_reg  <= row_count_next;
            dest_x_acc_reg <= dest_x_acc_next;
            dest_y_acc_reg <= dest_y_acc_next;
        end
    end

    // ------------------------------------------------------------------
    // Palette compare chain
    // ------------------------------------------------------------------
    assign chain_valid[0]          = src_valid;
    assign chain_req[0].x          = dest_x_acc_reg;
    assign chain_req[0].y          = dest_y_acc_reg;
    assign chain_req[0].size       = scale;
    assign chain_req[0].pixel      = src_pixel;
    assign chain_req[0].frame_end  = frame_last;
    assign chain_req[0].quant      = quant;
    assign chain_best[0].distance  = '1;
    assign chain_best[0].color     = '0;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        sbpq_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (CELL_IDX_W'(i)),
            .up_valid   (chain_valid[i]),
            .up_ready   (chain_ready[i]),
            .up_req     (chain_req[i]),
            .up_best    (chain_best[i]),
            .dn_valid   (chain_valid[i+1]),
            .dn_ready   (chain_ready[i+1]),
            .dn_req     (chain_req[i+1]),
            .dn_best    (chain_best[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    assign chain_ready[NCELL] = !fill_valid_reg || fill_ready;
    assign fill_load          = chain_valid[NCELL] && chain_ready[NCELL];
    assign fill_valid_next    = chain_ready[NCELL] ? chain_valid[NCELL] : fill_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_valid_reg <= 1'b0;
        end
        else
        begin
            fill_valid_reg <= fill_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill_load)
        begin
            fill_x_reg     <= chain_req[NCELL].x;
            fill_y_reg     <= chain_req[NCELL].y;
            fill_size_reg  <= chain_req[NCELL].size;
            frame_end_reg  <= chain_req[NCELL].frame_end;
            fill_color_reg <= (chain_req[NCELL].quant == QUANT_RAW) ?
                              chain_req[NCELL].pixel :
                              {{(PIX_W - RGB_W){1'b0}}, chain_best[NCELL].color};
        end
    end

    assign fill_valid = fill_valid_reg;
    assign fill_x     = fill_x_reg;
    assign fill_y     = fill_y_reg;
    assign fill_size  = fill_size_reg;
    assign fill_color = fill_color_reg;
    assign frame_end  = frame_end_reg;

`ifndef SYNTHESIS
    // End of a row restarts the column and the x corner
    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (src_accept && row_last) |=> (col_count_reg == '0) && (dest_x_acc_reg == '0))
        else $error("row wrap did not clear column state");

    // End of the frame restarts the row and the y corner
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (src_accept && frame_last) |=> (row_count_reg == '0) && (dest_y_acc_reg == '0))
        else $error("frame wrap did not clear row state");

    // Counters stay inside the source frame
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_count_reg <= COL_W'(SRC_WIDTH - 1)) &&
        (row_count_reg <= ROW_W'(SRC_HEIGHT - 1)))
        else $error("raster counter out of range");

    // A delivered square is never empty nor above the cap
    a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_valid |-> (fill_size != '0) && (fill_size <= SIZE_W'(MAX_FILL)))
        else $error("fill size out of range");

    // Counters hold when no pixel is taken
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !src_accept |=> $stable(col_count_reg) && $stable(row_count_reg))
        else $error("raster counter moved without a pixel");
`endif

endmodule

// ----- test/scaled_blit_palette_quantizer_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scaled_blit_palette_quantizer_test: self-checking bench for the blit block
// Streams source pixels through the valid/ready source port. Predicts every
// fill command (corner, square size, palette-mapped or raw color, frame end)
// in a scoreboard and compares each accepted command field by field. The
// register settings cover plain copy, EGA and CGA quantizing, small and large
// destinations, and register changes in the middle of a frame.
// ----------------------------------------------------------------------------
module scaled_blit_palette_quantizer_test;
    import sbpq_pkg::*;

    // Palette mode codes without a package name
    localparam logic [MODE_W-1:0] MODE_CGA     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CGA_ALT = 2'd3;

    // Palette tables, entry 0 in the low bits
    localparam logic [EGA_N*RGB_W-1:0] EGA_TABLE = {
        24'hFFFFFF, 24'hFFFF55, 24'hFF55FF, 24'hFF5555,
        24'h55FFFF, 24'h55FF55, 24'h5555FF, 24'h555555,
        24'hAAAAAA, 24'hAA5500, 24'hAA00AA, 24'hAA0000,
        24'h00AAAA, 24'h00AA00, 24'h0000AA, 24'h000000
    };
    localparam logic [CGA_N*RGB_W-1:0] CGA_TABLE = {
        24'hFFFFFF, 24'hFF55FF, 24'h55FFFF, 24'h000000
    };

    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_PIXELS   = 95;
    localparam int HOLD_AT        = 450;
    localparam int HOLD_CYCLES    = 120;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 60;

    // One fill command as seen on the output port
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SIZE_W-1:0]  size;
        logic [PIX_W-1:0]   color;
        logic               frame_end;
    } fill_cmd_t;

    // ------------------------------------------------------------------------
    // Scoreboard: register shadow, frame position and pending fill commands
    // ------------------------------------------------------------------------
    class blit_scoreboard;
        fill_cmd_t          due_fills[$];
        logic [MODE_W-1:0]  pal_mode;
        logic               scale_on;
        logic [COORD_W-1:0] dest_w;
        logic [COORD_W-1:0] dest_h;
        int unsigned        src_col;
        int unsigned        src_row;
        logic [COORD_W-1:0] x_acc;
        logic [COORD_W-1:0] y_acc;
        int unsigned        errors;
        int unsigned        pixels_in;
        int unsigned        fills_out;
        int unsigned        frames_done;
        int unsigned        frame_ends_seen;

        function new();
            pal_mode        = PAL_MODE_OFF;
            scale_on        = 1'b1;
            dest_w          = DEST_WIDTH_RST;
            dest_h          = DEST_HEIGHT_RST;
            src_col         = 0;
            src_row         = 0;
            x_acc           = '0;
            y_acc           = '0;
            errors          = 0;
            pixels_in       = 0;
            fills_out       = 0;
            frames_done     = 0;
            frame_ends_seen = 0;
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] val);
            case (idx)
                REG_PALETTE_MODE: pal_mode = val[MODE_W-1:0];
                REG_SCALE_ENABLE: scale_on = val[0];
                REG_DEST_WIDTH:   dest_w   = val[COORD_W-1:0];
                REG_DEST_HEIGHT:  dest_h   = val[COORD_W-1:0];
                default: ;
            endcase
        endfunction

        // Nearest palette entry by sum of channel distances, first entry on ties
        function logic [RGB_W-1:0] nearest_rgb(logic [RGB_W-1:0] rgb, quant_t q);
            int unsigned        count;
            int unsigned        l1;
            int unsigned        best_dist;
            int unsigned        a;
            int unsigned        b;
            logic [RGB_W-1:0]   entry;
            logic [RGB_W-1:0]   best;
            count     = (q == QUANT_EGA) ? EGA_N : CGA_N;
            best_dist = 3 * 256;
            best      = '0;
            for (int i = 0; i < count; i++) begin
                entry = (q == QUANT_EGA) ? EGA_TABLE[i*RGB_W +: RGB_W]
                                         : CGA_TABLE[i*RGB_W +: RGB_W];
                l1 = 0;
                for (int k = 0; k < 3; k++) begin
                    a = rgb[k*CHAN_W +: CHAN_W];
                    b = entry[k*CHAN_W +: CHAN_W];
                    l1 += (a > b) ? a - b : b - a;
                end
                if (l1 < best_dist) begin
                    best_dist = l1;
                    best      = entry;
                end
            end
            return best;
        endfunction

        // Accepted source pixel: compute its fill command and step the raster
        function void note_pixel(logic [PIX_W-1:0] pix);
            fill_cmd_t   cmd;
            logic        scaled;
            logic        row_last;
            int unsigned scale;
            int unsigned sx;
            int unsigned sy;
            quant_t      q;
            scaled = scale_on && (dest_w != SRC_WIDTH || dest_h != SRC_HEIGHT);
            scale  = 1;
            q      = QUANT_RAW;
            if (scaled) begin
                sx    = dest_w / SRC_WIDTH;
                sy    = dest_h / SRC_HEIGHT;
                scale = (sx < sy) ? sx : sy;
                if (scale < 1)
                    scale = 1;
                if (scale > MAX_FILL)
                    scale = MAX_FILL;
                if (pal_mode == PAL_MODE_EGA)
                    q = QUANT_EGA;
                else if (pal_mode != PAL_MODE_OFF)
                    q = QUANT_CGA;
            end
            row_last      = src_col >= SRC_WIDTH - 1;
            cmd.x         = x_acc;
            cmd.y         = y_acc;
            cmd.size      = SIZE_W'(scale);
            cmd.color     = (q == QUANT_RAW) ? pix : {8'h00, nearest_rgb(pix[RGB_W-1:0], q)};
            cmd.frame_end = row_last && src_row >= SRC_HEIGHT - 1;
            due_fills.push_back(cmd);
            pixels_in++;

            if (row_last) begin
                src_col = 0;
                x_acc   = '0;
                if (cmd.frame_end) begin
                    src_row = 0;
                    y_acc   = '0;
                    frames_done++;
                end else begin
                    src_row = src_row + 1;
                    y_acc   = y_acc + COORD_W'(scale);
                end
            end else begin
                src_col = src_col + 1;
                x_acc   = x_acc + COORD_W'(scale);
            end
        endfunction

        function void report_field(string field, longint unsigned want, longint unsigned got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
        endfunction

        // Accepted fill command: compare with the oldest prediction
        function void check_fill(fill_cmd_t got);
            fill_cmd_t want;
            fills_out++;
            if (got.frame_end === 1'b1)
                frame_ends_seen++;
            if (due_fills.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected fill command, expected none, actual 0x%0h",
                             $time, got);
                return;
            end
            want = due_fills.pop_front();
            if (got.x !== want.x)
                report_field("fill_x", want.x, got.x);
            if (got.y !== want.y)
                report_field("fill_y", want.y, got.y);
            if (got.size !== want.size)
                report_field("fill_size", want.size, got.size);
            if (got.color !== want.color)
                report_field("fill_color", want.color, got.color);
            if (got.frame_end !== want.frame_end)
                report_field("frame_end", want.frame_end, got.frame_end);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [PADDR_W-1:0] paddr      = '0;
    logic [PDATA_W-1:0] pwdata     = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               src_valid  = 1'b0;
    logic               src_ready;
    logic [PIX_W-1:0]   src_pixel  = '0;
    logic               fill_valid;
    logic               fill_ready = 1'b0;
    logic [COORD_W-1:0] fill_x;
    logic [COORD_W-1:0] fill_y;
    logic [SIZE_W-1:0]  fill_size;
    logic [PIX_W-1:0]   fill_color;
    logic               frame_end;

    blit_scoreboard sb = new();
    bit          src_calm;
    bit          sink_calm;
    bit          hold_done;
    int unsigned settings_used;
    int unsigned quiet_cycles;

    always #1 clk = ~clk;

    scaled_blit_palette_quantizer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .src_valid  (src_valid),
        .src_ready  (src_ready),
        .src_pixel  (src_pixel),
        .fill_valid (fill_valid),
        .fill_ready (fill_ready),
        .fill_x     (fill_x),
        .fill_y     (fill_y),
        .fill_size  (fill_size),
        .fill_color (fill_color),
        .frame_end  (frame_end)
    );

    // ------------------------------------------------------------------------
    // Watchdog: ends the run after a long stretch with no transfer at all
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if ((src_valid && src_ready) || (fill_valid && fill_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("scaled_blit_palette_quantizer test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Fill sink: random ready gaps, calm stretches, one long hold-off
    // ------------------------------------------------------------------------
    initial begin : fill_sink
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (sb.fills_out % 64 == 0)
                sink_calm = ($urandom_range(0, 3) == 0);
            if (!hold_done && sb.fills_out == HOLD_AT) begin
                hold_done = 1'b1;
                gap       = HOLD_CYCLES;
            end else if (sink_calm) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 4);
            end
            if (gap > 0) begin
                fill_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            fill_ready <= 1'b1;
            do @(posedge clk); while (!fill_valid);
            sb.check_fill({fill_x, fill_y, fill_size, fill_color, frame_end});
        end
    end

    // ------------------------------------------------------------------------
    // Source and register tasks (called right after a rising edge)
    // ------------------------------------------------------------------------
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit sparse = 1'b0);
        int gap;
        if (src_calm)
            gap = 0;
        else if (sparse)
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 4) : 0;
        else
            gap = $urandom_range(0, 4);
        if (gap > 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_pixel <= pix;
        do @(posedge clk); while (!src_ready);
        sb.note_pixel(pix);
    endtask

    // Drop valid and wait until every predicted fill has come out
    task automatic settle();
        src_valid <= 1'b0;
        while (sb.due_fills.size() != 0)
            @(posedge clk);
    endtask

    // Register write; psel is released by the caller after the last one
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_config(input logic [MODE_W-1:0] mode, input logic en,
                                input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h);
        write_reg(REG_PALETTE_MODE, PDATA_W'(mode));
        write_reg(REG_SCALE_ENABLE, PDATA_W'(en));
        write_reg(REG_DEST_WIDTH, PDATA_W'(w));
        write_reg(REG_DEST_HEIGHT, PDATA_W'(h));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Destination extent: edges, source size, multiples and random values
    function automatic logic [COORD_W-1:0] pick_extent(input int src);
        case ($urandom_range(0, 5))
            0:       return COORD_W'(1);
            1:       return COORD_W'(src - 1);
            2:       return COORD_W'(src);
            3:       return COORD_W'(src * $urandom_range(2, 12));
            4:       return {COORD_W{1'b1}};
            default: return COORD_W'($urandom_range(1, 4095));
        endcase
    endfunction

    task automatic apply_random_config();
        logic [MODE_W-1:0]  mode;
        logic               en;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        mode = MODE_W'($urandom_range(0, 3));
        en   = ($urandom_range(0, 4) != 0);
        w    = pick_extent(SRC_WIDTH);
        h    = pick_extent(SRC_HEIGHT);
        if ($urandom_range(0, 5) == 0) begin
            w = COORD_W'(SRC_WIDTH);
            h = COORD_W'(SRC_HEIGHT);
        end
        apply_config(mode, en, w, h);
    endtask

    // Random pixel: fully random, near a palette entry, or on level steps
    function automatic logic [PIX_W-1:0] pick_pixel();
        logic [PIX_W-1:0] pix;
        int               levels[8] = '{8'h00, 8'h2A, 8'h55, 8'h7F, 8'h80, 8'hAA, 8'hD4, 8'hFF};
        case ($urandom_range(0, 3))
            0: begin
                pix = {8'($urandom), EGA_TABLE[$urandom_range(0, EGA_N - 1)*RGB_W +: RGB_W]};
                pix = pix ^ ($urandom & 32'h0003_0303);
            end
            1: pix = {8'($urandom), 8'(levels[$urandom_range(0, 7)]),
                      8'(levels[$urandom_range(0, 7)]), 8'(levels[$urandom_range(0, 7)])};
            default: pix = $urandom;
        endcase
        return pix;
    endfunction

    task automatic run_random(input int count, input bit sparse);
        for (int i = 0; i < count; i++)
            send_pixel(pick_pixel(), sparse);
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: destination equals source, plain copy
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        settle();

        // EGA selected but destination equals source: still raw words
        apply_config(PAL_MODE_EGA, 1'b1, COORD_W'(SRC_WIDTH), COORD_W'(SRC_HEIGHT));
        send_pixel(32'hFF12_3456);
        send_pixel(32'h00AA_AA55);
        settle();

        // EGA at the largest scale; ties, top byte ignored, channel extremes
        apply_config(PAL_MODE_EGA, 1'b1, 12'hFFF, 12'hFFF);
        send_pixel(32'h0000_0055);
        send_pixel(32'hFF00_00AA);
        send_pixel(32'h12AA_5500);
        send_pixel(32'h0055_5555);
        send_pixel(32'h007F_7F7F);
        send_pixel(32'h00FF_FFFF);
        send_pixel(32'h8080_8080);
        send_pixel(32'hFFFF_FFFF);
        settle();

        // Mode three acts as CGA; tiny destination gives scale one
        apply_config(MODE_CGA_ALT, 1'b1, 12'd1, 12'd1);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0055_FFFF);
        send_pixel(32'h00AA_AAAA);
        send_pixel(32'h00FF_55FF);
        send_pixel(32'h007F_7F7F);
        settle();

        // Scaling disabled: raw word whatever the mode
        apply_config(MODE_CGA, 1'b0, 12'hFFF, 12'hFFF);
        send_pixel(32'hDEAD_BEEF);
        send_pixel(32'h0000_00AA);
        settle();

        // Height limits the scale to one, quantizing still on
        apply_config(PAL_MODE_EGA, 1'b1, 12'hFFF, COORD_W'(SRC_HEIGHT));
        send_pixel(32'h00AA_5501);
        send_pixel(32'h7F00_7F00);
        settle();

        // Random phases, a new register setting each time
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            apply_random_config();
            src_calm = ($urandom_range(0, 3) == 0);
            run_random(PHASE_PIXELS, 1'b0);
        end

        // Last phase with only occasional source gaps
        src_calm = 1'b0;
        apply_random_config();
        run_random(PHASE_PIXELS, 1'b1);

        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.errors += sb.due_fills.size();

        $display("Covered %0d pixels and %0d fill commands over %0d register settings.",
                 sb.pixels_in, sb.fills_out, settings_used);
        $display("Frames completed: %0d, frame ends seen: %0d, errors: %0d.",
                 sb.frames_done, sb.frame_ends_seen, sb.errors);
        if (sb.errors == 0)
            $display("scaled_blit_palette_quantizer test passed");
        else
            $display("scaled_blit_palette_quantizer test failed");
        $finish;
    end

endmodule
